// ===== rtl/core/pixel_program_cpu_macros.svh =====
// assertion macros shared by the pixel program cpu rtl
`ifndef PIXEL_PROGRAM_CPU_MACROS_SVH
`define PIXEL_PROGRAM_CPU_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, disabled while in reset
`define PPC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pixel_program_cpu: assertion failed");
// next-cycle implication, disabled while in reset
`define PPC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pixel_program_cpu: assertion failed");
`else
`define PPC_ASSERT_IMP(label, clk, rst, ante, cons)
`define PPC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/core/ppc_pkg.sv =====
// types and constants of the pixel program cpu
package ppc_pkg;

  // default sizes
  localparam int PPC_PROGRAM_WORDS = 16;
  localparam int PPC_NUM_REGS      = 8;
  localparam int PPC_REG_WIDTH     = 4;

  // fixed field widths
  localparam int OPC_W   = 4;
  localparam int OPND_W  = 8;
  localparam int ADDR_W  = 4;
  localparam int PIXEL_W = 4;
  localparam int WORD_W  = OPC_W + 3 * OPND_W;
  localparam int LFSR_W  = 8;

  localparam logic [LFSR_W-1:0] LFSR_RESET = 8'h01;

  // instruction set
  typedef enum logic [OPC_W-1:0] {
    OP_NOOP, OP_GETX, OP_GETY, OP_GETTIME, OP_MOV, OP_ADD, OP_SUB, OP_SL,
    OP_SR, OP_RAND, OP_AND, OP_NAND, OP_OR, OP_NOR, OP_XOR, OP_SET
  } op_t;

  // fibonacci lfsr, taps x^8+x^6+x^5+x^4+1
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
    lfsr_step = {s[6:0], s[7] ^ s[5] ^ s[4] ^ s[3]};
  endfunction

endpackage

// ===== rtl/core/pixel_program_cpu.sv =====
// pixel program cpu: program store, register bank and three-stage sequencer
//
// Command interface. A transaction is accepted at a rising edge with start
// high and busy low. req_type 0 loads one program word (opcode, op_a, op_b,
// op_c) at prog_addr; it completes at that edge, busy stays low and no result
// follows. req_type 1 runs the whole program for one pixel (pixel_x, pixel_y,
// frame_time are captured at acceptance).
// A run walks the program store through a fetch, register read and execute
// pipeline, one program word per cycle, with write-back forwarding into the
// execute stage. After the last word one extra slot reads register 0.
// busy is high from the acceptance of a run until the tail slot leaves the
// execute stage, and the result shows on pixel_value with done high for one
// cycle, registered from the tail slot in the execute stage. The next
// transaction can be accepted in the cycle done is high.
// The receiver cannot stall: each result is presented for exactly one cycle.
// Reset clears the program store to NOOP words (per-word valid bits), the
// register bank, the sequencer and sets the random generator to one; the
// generator keeps its value from run to run.
`include "pixel_program_cpu_macros.svh"

module pixel_program_cpu
  import ppc_pkg::*;
#(
  parameter int PROGRAM_WORDS = PPC_PROGRAM_WORDS,
  parameter int NUM_REGS      = PPC_NUM_REGS,
  parameter int REG_WIDTH     = PPC_REG_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               req_type,
  input  logic [ADDR_W-1:0]  prog_addr,
  input  logic [OPC_W-1:0]   opcode,
  input  logic [OPND_W-1:0]  op_a,
  input  logic [OPND_W-1:0]  op_b,
  input  logic [OPND_W-1:0]  op_c,
  input  logic [OPND_W-1:0]  pixel_x,
  input  logic [OPND_W-1:0]  pixel_y,
  input  logic [OPND_W-1:0]  frame_time,
  output logic               done,
  output logic [PIXEL_W-1:0] pixel_value
);

  localparam int PAW  = (PROGRAM_WORDS > 1) ? $clog2(PROGRAM_WORDS) : 1;
  localparam int CNTW = $clog2(PROGRAM_WORDS + 1);
  localparam int RAW  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int RW   = REG_WIDTH;

  // transaction decode
  logic accept, run_fire, load_fire;
  assign accept    = start && !busy;
  assign run_fire  = accept && req_type;
  assign load_fire = accept && !req_type && (32'(prog_addr) < 32'(PROGRAM_WORDS));

  // sequencer control
  logic            f_run;
  logic [CNTW-1:0] f_cnt;
  logic            d_vld, d_tail, x_vld, x_tail;
  logic [LFSR_W-1:0] lfsr;

  assign busy = f_run || d_vld || x_vld;

  // captured pixel inputs
  logic [OPND_W-1:0] px, py, pt;

  // program store
  logic [WORD_W-1:0]        prog_mem [PROGRAM_WORDS];
  logic [PROGRAM_WORDS-1:0] prog_valid;
  logic [WORD_W-1:0]        prog_rdata;
  logic                     prog_rvld;
  logic [PAW-1:0]           f_idx;
  logic [PAW-1:0]           load_idx;

  assign f_idx    = f_cnt[PAW-1:0];
  assign load_idx = PAW'(prog_addr);

  always_ff @(posedge clk) begin
    if (load_fire) begin
      prog_mem[load_idx] <= {opcode, op_a, op_b, op_c};
    end
    prog_rdata <= prog_mem[f_idx];
    prog_rvld  <= prog_valid[f_idx];
  end

  // decode stage: word from the store, tail slot reads register 0
  logic [WORD_W-1:0] d_word;
  op_t               d_op;
  logic [OPND_W-1:0] d_a, d_b, d_c;
  logic              a_ok, b_ok;
  logic [RAW-1:0]    ia, ib;

  assign d_word = prog_rvld ? prog_rdata : '0;

  always_comb begin
    d_op = op_t'(d_word[WORD_W-1 -: OPC_W]);
    d_a  = d_word[3*OPND_W-1 -: OPND_W];
    d_b  = d_word[2*OPND_W-1 -: OPND_W];
    d_c  = d_word[OPND_W-1:0];
    if (d_tail) begin
      d_op = OP_NOOP;
      d_a  = '0;
    end
  end

  assign a_ok = 32'(d_a) < 32'(NUM_REGS);
  assign b_ok = 32'(d_b) < 32'(NUM_REGS);
  assign ia   = a_ok ? RAW'(d_a) : '0;
  assign ib   = b_ok ? RAW'(d_b) : '0;

  // register bank
  logic [RW-1:0]       reg_mem [NUM_REGS];
  logic [NUM_REGS-1:0] reg_valid;
  logic [RW-1:0]       ra_q, rb_q;
  logic                ra_ok, rb_ok;

  // write-back stage for forwarding
  logic              wb_en;
  logic [OPND_W-1:0] wb_idx;
  logic [RW-1:0]     wb_data;

  // execute stage
  op_t               x_op;
  logic [OPND_W-1:0] x_a, x_b, x_c;
  logic [RW-1:0]     va, vb;
  logic              has_dest, dest_ok, wr_en, sh_big;
  logic [OPND_W-1:0] dest;
  logic [RW-1:0]     wr_data;
  logic [RAW-1:0]    widx;
  logic [LFSR_W-1:0] lfsr_next;

  assign lfsr_next = lfsr_step(lfsr);

  // operand forwarding from the write just committed
  assign va = (wb_en && wb_idx == x_a) ? wb_data : (ra_ok ? ra_q : '0);
  assign vb = (wb_en && wb_idx == x_b) ? wb_data : (rb_ok ? rb_q : '0);
  assign sh_big = 32'(vb) >= 32'(REG_WIDTH);

  // alu and destination select
  always_comb begin
    has_dest = 1'b1;
    dest     = x_c;
    wr_data  = '0;
    case (x_op)
      OP_GETX:    begin dest = x_a; wr_data = RW'(px); end
      OP_GETY:    begin dest = x_a; wr_data = RW'(py); end
      OP_GETTIME: begin dest = x_a; wr_data = RW'(pt); end
      OP_MOV:     begin dest = x_b; wr_data = va; end
      OP_ADD:     wr_data = va + vb;
      OP_SUB:     wr_data = va - vb;
      OP_SL:      wr_data = sh_big ? '0 : (va << vb);
      OP_SR:      wr_data = sh_big ? '0 : (va >> vb);
      OP_RAND:    begin dest = x_a; wr_data = RW'(lfsr_next); end
      OP_AND:     wr_data = va & vb;
      OP_NAND:    wr_data = ~(va & vb);
      OP_OR:      wr_data = va | vb;
      OP_NOR:     wr_data = ~(va | vb);
      OP_XOR:     wr_data = va ^ vb;
      OP_SET:     begin dest = x_a; wr_data = RW'(x_b); end
      default:    has_dest = 1'b0;
    endcase
  end

  assign dest_ok = 32'(dest) < 32'(NUM_REGS);
  assign wr_en   = x_vld && has_dest && dest_ok;
  assign widx    = dest_ok ? RAW'(dest) : '0;

  // register bank access: two registered reads, one write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      reg_mem[widx] <= wr_data;
    end
    ra_q <= reg_mem[ia];
    rb_q <= reg_mem[ib];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      f_run      <= 1'b0;
      f_cnt      <= '0;
      d_vld      <= 1'b0;
      d_tail     <= 1'b0;
      x_vld      <= 1'b0;
      x_tail     <= 1'b0;
      done       <= 1'b0;
      wb_en      <= 1'b0;
      lfsr       <= LFSR_RESET;
      prog_valid <= '0;
      reg_valid  <= '0;
      ra_ok      <= 1'b0;
      rb_ok      <= 1'b0;
    end else begin
      // fetch slots 0..PROGRAM_WORDS, the last one being the tail
      if (run_fire) begin
        f_run <= 1'b1;
        f_cnt <= '0;
      end else if (f_run) begin
        if (32'(f_cnt) == 32'(PROGRAM_WORDS)) begin
          f_run <= 1'b0;
        end
        f_cnt <= f_cnt + 1'b1;
      end
      d_vld  <= f_run;
      d_tail <= f_run && (32'(f_cnt) == 32'(PROGRAM_WORDS));
      x_vld  <= d_vld;
      x_tail <= d_vld && d_tail;
      done   <= x_vld && x_tail;
      wb_en  <= wr_en;
      ra_ok  <= a_ok && reg_valid[ia];
      rb_ok  <= b_ok && reg_valid[ib];
      if (load_fire) begin
        prog_valid[load_idx] <= 1'b1;
      end
      // bank reads as zero at the start of every run
      if (run_fire) begin
        reg_valid <= '0;
      end else if (wr_en) begin
        reg_valid[widx] <= 1'b1;
      end
      if (x_vld && x_op == OP_RAND) begin
        lfsr <= lfsr_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (run_fire) begin
      px <= pixel_x;
      py <= pixel_y;
      pt <= frame_time;
    end
    x_op    <= d_op;
    x_a     <= d_a;
    x_b     <= d_b;
    x_c     <= d_c;
    wb_idx  <= dest;
    wb_data <= wr_data;
    if (x_vld && x_tail) begin
      pixel_value <= PIXEL_W'(va);
    end
  end

  // checks
  `PPC_ASSERT_NXT(a_run_busy, clk, rst, run_fire, busy)
  `PPC_ASSERT_NXT(a_load_idle, clk, rst, accept && !req_type && !busy, !busy)
  `PPC_ASSERT_NXT(a_tail_done, clk, rst, x_vld && x_tail, done)
  `PPC_ASSERT_IMP(a_tail_single, clk, rst, 1'b1, $onehot0({d_tail, x_tail}))
  `PPC_ASSERT_IMP(a_wr_range, clk, rst, wr_en, 32'(dest) < 32'(NUM_REGS))

endmodule
